>>> hdl/ipl4x_pkg.sv
// Shared types, constants and helpers for the IPv4 L4 payload XOR and checksum block.
`timescale 1ns / 1ps

package ipl4x_pkg;

	// Protocol numbers of the transport layers that are handled
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Byte offset of the check field inside the L4 header
	localparam logic [6:0] CHK_OFF_TCP = 7'd16;
	localparam logic [6:0] CHK_OFF_UDP = 7'd6;

	// Fixed header sizes
	localparam logic [3:0] IHL_MIN       = 4'd5;
	localparam logic [5:0] TCP_HDR_MIN   = 6'd20;
	localparam logic [5:0] UDP_HDR_BYTES = 6'd8;

	// IPv4 header byte positions
	localparam logic [15:0] POS_VER_IHL = 16'd0;
	localparam logic [15:0] POS_LEN_HI  = 16'd2;
	localparam logic [15:0] POS_LEN_LO  = 16'd3;
	localparam logic [15:0] POS_PROTO   = 16'd9;
	localparam logic [15:0] POS_SRC     = 16'd12;
	localparam logic [15:0] POS_DST_END = 16'd19;
	localparam logic [15:0] POS_TCP_DOFF_REL = 16'd12;

	// Byte position saturates at the largest packet size
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CSUM_ENABLE = 2'd1;

	// Per-byte result of the parse stage
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic        transport;
		logic        csum_go;
		logic        tcp;
		logic [15:0] sum;
		logic [7:0]  proto;
		logic [15:0] len_diff;
		logic [6:0]  offset;
	} ipl4x_item_t;

	// Ones-complement add of two folded 16-bit values with end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

>>> hdl/ipv4_l4_payload_xor_checksum.sv
// Top level: IPv4 TCP/UDP payload XOR with L4 checksum recompute on a byte stream.
// Each accepted input byte is registered in the parse stage, then in the output register.
// Throughput: one byte per cycle while m_axis_tready keeps the output draining; the parse
// stage and the checksum finish stage each hold one byte, and both advance whenever the output register drains.
// Reset: arst_n clears the packet state, the stage valids, xor_key to 0 and
// csum_enable to 1; the block takes bytes right after reset.
`timescale 1ns / 1ps

module ipv4_l4_payload_xor_checksum import ipl4x_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input byte stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
	input  logic                 s_axis_tlast,
	// Output byte stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // [7:0] out_byte, [23:8] csum_value,
	                                            // [30:24] csum_offset, [31] zero
	output logic                 m_axis_tlast,
	output logic [1:0]           m_axis_tuser,  // [0] is_transport, [1] csum_valid
	// Configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic        xor_key_q;
	logic [7:0]  key_q;
	logic        csum_en_q;
	logic        in_acc;
	logic        s1_valid_q;
	logic        out_valid_q;
	logic        s2_load;
	logic        s1_adv;
	ipl4x_item_t item;
	ipl4x_item_t item_s1;

	logic [7:0]  byte_s2;
	logic        last_s2;
	logic        transport_s2;
	logic        go_s2;
	logic [15:0] value_s2;
	logic [6:0]  offset_s2;

	logic [15:0] fin_a;
	logic [15:0] fin_b;
	logic [15:0] fin_c;
	logic [15:0] fin_val;

	assign xor_key_q = 1'b0;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= 8'd0;
			csum_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_XOR_KEY:     key_q     <= cfg_data;
				CFG_CSUM_ENABLE: csum_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	assign s2_load       = !out_valid_q || m_axis_tready;
	assign s1_adv        = s1_valid_q && s2_load;
	assign s_axis_tready = !s1_valid_q || s2_load;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	ipl4x_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.xor_key     (key_q ^ {8{xor_key_q}}),
		.csum_enable (csum_en_q),
		.item        (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Capture the parsed byte
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item;
		end
	end

	// Finish the checksum: add protocol and L4 length, invert, map UDP zero
	assign fin_a   = ones_add(item_s1.sum, {8'h00, item_s1.proto});
	assign fin_b   = ones_add(fin_a, item_s1.len_diff);
	assign fin_c   = ~fin_b;
	assign fin_val = (!item_s1.tcp && fin_c == 16'h0000) ? 16'hFFFF : fin_c;

	// Output register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			byte_s2      <= item_s1.out_byte;
			last_s2      <= item_s1.last;
			transport_s2 <= item_s1.transport;
			go_s2        <= item_s1.csum_go;
			value_s2     <= item_s1.csum_go ? fin_val : 16'h0000;
			offset_s2    <= item_s1.csum_go ? item_s1.offset : 7'd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, offset_s2, value_s2, byte_s2};
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = {go_s2, transport_s2};

endmodule

>>> hdl/ipl4x_parser.sv
// Per-packet header tracking, payload XOR and running ones-complement sum.
`timescale 1ns / 1ps

module ipl4x_parser import ipl4x_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic [7:0]  xor_key,
	input  logic        csum_enable,
	output ipl4x_item_t item
);

	logic [15:0] pos_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [15:0] tl_q;
	logic [5:0]  thb_q;
	logic [15:0] sum_q;

	logic [3:0]  hw_cur;
	logic [7:0]  proto_cur;
	logic [15:0] tl_cur;
	logic [5:0]  thb_cur;
	logic [5:0]  hdr;
	logic [15:0] hdr16;
	logic        is_tcp;
	logic        is_transport;
	logic [6:0]  chk;
	logic [15:0] chk16;
	logic        in_seg;
	logic [15:0] rel;
	logic [5:0]  doff;
	logic [5:0]  doff_clamp;
	logic [5:0]  start;
	logic [7:0]  ob;
	logic        hdr_sum;
	logic        seg_sum;
	logic [15:0] add_val;
	logic [15:0] sum_nx;
	logic [6:0]  off;
	logic [15:0] off1;
	logic        off_ok;

	// Header fields as seen with the current byte applied
	always_comb begin
		hw_cur = hw_q;
		if (pos_q == POS_VER_IHL) begin
			hw_cur = (in_byte[3:0] < IHL_MIN) ? IHL_MIN : in_byte[3:0];
		end
		tl_cur = tl_q;
		if (pos_q == POS_LEN_HI) begin
			tl_cur = {in_byte, tl_q[7:0]};
		end else if (pos_q == POS_LEN_LO) begin
			tl_cur = {tl_q[15:8], in_byte};
		end
		proto_cur = (pos_q == POS_PROTO) ? in_byte : proto_q;
	end

	assign hdr          = {hw_cur, 2'b00};
	assign hdr16        = {10'd0, hdr};
	assign is_tcp       = (proto_cur == PROTO_TCP);
	assign is_transport = is_tcp || (proto_cur == PROTO_UDP);
	assign chk          = is_tcp ? CHK_OFF_TCP : CHK_OFF_UDP;
	assign chk16        = {9'd0, chk};

	// Byte lies within the L4 segment
	assign in_seg = is_transport && (pos_q >= hdr16) && (pos_q < tl_cur) && (pos_q != POS_MAX);
	assign rel    = pos_q - hdr16;

	// TCP data offset, clamped to the minimum header size
	assign doff       = {in_byte[7:4], 2'b00};
	assign doff_clamp = (doff < TCP_HDR_MIN) ? TCP_HDR_MIN : doff;

	always_comb begin
		thb_cur = thb_q;
		if (pos_q == POS_VER_IHL) begin
			thb_cur = TCP_HDR_MIN;
		end else if (in_seg && is_tcp && rel == POS_TCP_DOFF_REL) begin
			thb_cur = doff_clamp;
		end
	end

	assign start = is_tcp ? thb_cur : UDP_HDR_BYTES;
	assign ob    = (in_seg && rel >= {10'd0, start}) ? (in_byte ^ xor_key) : in_byte;

	// Sum the addresses of the pseudo header and the segment, skipping the check field
	assign hdr_sum = (pos_q >= POS_SRC) && (pos_q <= POS_DST_END);
	assign seg_sum = in_seg && (rel != chk16) && (rel != chk16 + 16'd1);
	assign add_val = pos_q[0] ? {8'h00, ob} : {ob, 8'h00};
	assign sum_nx  = (hdr_sum || seg_sum) ? ones_add(sum_q, add_val) : sum_q;

	// Check field must lie below total length and have arrived
	assign off    = {1'b0, hdr} + chk;
	assign off1   = {9'd0, off} + 16'd1;
	assign off_ok = (off1 < tl_cur) && (pos_q >= off1);

	always_comb begin
		item.out_byte  = ob;
		item.last      = in_last;
		item.transport = in_last && is_transport;
		item.csum_go   = in_last && is_transport && csum_enable && off_ok;
		item.tcp       = is_tcp;
		item.sum       = sum_nx;
		item.proto     = proto_cur;
		item.len_diff  = tl_cur - hdr16;
		item.offset    = off;
	end

	// Advance packet state on each transfer, clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			tl_q    <= '0;
			thb_q   <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q   <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				tl_q    <= '0;
				thb_q   <= '0;
				sum_q   <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				hw_q    <= hw_cur;
				proto_q <= proto_cur;
				tl_q    <= tl_cur;
				thb_q   <= thb_cur;
				sum_q   <= sum_nx;
			end
		end
	end

endmodule

>>> tb/ipv4_l4_payload_xor_checksum_tb.sv
// Self-checking testbench for the IPv4 L4 payload XOR and checksum stream block.
`timescale 1ns / 1ps

module ipv4_l4_payload_xor_checksum_tb;
	import ipl4x_pkg::*;

	// Register indexes that map to no register; writes to them change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic        is_transport;
		logic        csum_valid;
		logic [15:0] csum_value;
		logic [6:0]  csum_offset;
	} out_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	in_beat_t    ingress_q[$];
	out_beat_t   egress_due_q[$];
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned err_cnt = 0;

	// Shadow of the registers and of the per-packet parse state
	logic [7:0]  key_sh = 8'd0;
	logic        csum_en_sh = 1'b1;
	logic [15:0] pk_pos = '0;
	logic [3:0]  pk_ihl = '0;
	logic [7:0]  pk_proto = '0;
	logic [15:0] pk_tot_len = '0;
	logic [5:0]  pk_tcp_hlen = '0;
	logic [15:0] pk_sum = '0;

	ipv4_l4_payload_xor_checksum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fold a 32-bit sum to 16 bits with end-around carry
	function automatic logic [15:0] fold_to16(input logic [31:0] x);
		logic [31:0] s;
		s = {16'd0, x[15:0]} + {16'd0, x[31:16]};
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		return s[15:0];
	endfunction

	// Add a byte to the running sum at its weight within the 16-bit word
	function automatic logic [15:0] sum_at(input logic [31:0] pos, input logic [7:0] v);
		return fold_to16({16'd0, pk_sum} + (pos[0] ? {24'd0, v} : {16'd0, v, 8'd0}));
	endfunction

	// Work out the output transfer for one input byte and advance the parse state
	function automatic out_beat_t emulate_byte(input logic [7:0] b, input logic last);
		out_beat_t   r;
		logic [31:0] pos, hdr, chk, rel, start, off, s, d;
		logic [15:0] c;
		logic [7:0]  ob;
		logic        tcp, l4;
		pos = {16'd0, pk_pos};
		ob = b;
		// capture header fields, sum the address bytes
		if (pos == POS_VER_IHL) begin
			pk_ihl = (b[3:0] < IHL_MIN) ? IHL_MIN : b[3:0];
			pk_tcp_hlen = TCP_HDR_MIN;
		end else if (pos == POS_LEN_HI) begin
			pk_tot_len[15:8] = b;
		end else if (pos == POS_LEN_LO) begin
			pk_tot_len[7:0] = b;
		end else if (pos == POS_PROTO) begin
			pk_proto = b;
		end else if (pos >= POS_SRC && pos <= POS_DST_END) begin
			pk_sum = sum_at(pos, b);
		end
		hdr = {26'd0, pk_ihl, 2'b00};
		tcp = (pk_proto == PROTO_TCP);
		l4 = tcp || (pk_proto == PROTO_UDP);
		chk = tcp ? {25'd0, CHK_OFF_TCP} : {25'd0, CHK_OFF_UDP};
		// XOR the payload and sum the segment, skipping the check field
		if (l4 && pos >= hdr && pos < {16'd0, pk_tot_len} && pos < {16'd0, POS_MAX}) begin
			rel = pos - hdr;
			if (tcp && rel == POS_TCP_DOFF_REL) begin
				d = {26'd0, b[7:4], 2'b00};
				pk_tcp_hlen = (d < TCP_HDR_MIN) ? TCP_HDR_MIN : d[5:0];
			end
			start = tcp ? {26'd0, pk_tcp_hlen} : {26'd0, UDP_HDR_BYTES};
			if (rel >= start)
				ob = b ^ key_sh;
			if (rel != chk && rel != chk + 1)
				pk_sum = sum_at(pos, ob);
		end
		r = '0;
		r.out_byte = ob;
		r.out_last = last;
		if (last) begin
			r.is_transport = l4;
			off = hdr + chk;
			// patch only when both check bytes lie inside the length and have arrived
			if (l4 && csum_en_sh && off + 1 < {16'd0, pk_tot_len} && pos >= off + 1) begin
				s = {16'd0, fold_to16({16'd0, pk_sum} + {24'd0, pk_proto})};
				s = {16'd0, fold_to16(s + ({16'd0, pk_tot_len} - hdr))};
				c = ~s[15:0];
				if (!tcp && c == 16'd0)
					c = 16'hFFFF;
				r.csum_valid = 1'b1;
				r.csum_value = c;
				r.csum_offset = off[6:0];
			end
			pk_pos = '0;
			pk_ihl = '0;
			pk_proto = '0;
			pk_tot_len = '0;
			pk_tcp_hlen = '0;
			pk_sum = '0;
		end else if (pk_pos < POS_MAX) begin
			pk_pos = pk_pos + 16'd1;
		end
		return r;
	endfunction

	function automatic void cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	// Input driver: predict each accepted transfer, then offer the next byte
	always @(posedge clk or negedge arst_n) begin : drive_proc
		in_beat_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				egress_due_q.push_back(emulate_byte(s_axis_tdata, s_axis_tlast));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (ingress_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = ingress_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.data;
					s_axis_tlast <= nxt.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_proc
		out_beat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (egress_due_q.size() == 0) begin
					$error("output transfer with no byte outstanding");
					err_cnt++;
				end else begin
					want = egress_due_q.pop_front();
					cmp_field("out_byte", 16'(want.out_byte), 16'(m_axis_tdata[7:0]));
					cmp_field("out_last", 16'(want.out_last), 16'(m_axis_tlast));
					cmp_field("is_transport", 16'(want.is_transport),
						16'(m_axis_tuser[0]));
					cmp_field("csum_valid", 16'(want.csum_valid), 16'(m_axis_tuser[1]));
					cmp_field("csum_value", want.csum_value, m_axis_tdata[23:8]);
					cmp_field("csum_offset", 16'(want.csum_offset),
						16'(m_axis_tdata[30:24]));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Hold until every queued byte has gone in and every output has come back
	task automatic wait_drain();
		do
			@(negedge clk);
		while (ingress_q.size() != 0 || s_axis_tvalid || egress_due_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_XOR_KEY:     key_sh = val;
			CFG_CSUM_ENABLE: csum_en_sh = val[0];
			default: ;
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_beat_t t;
		t.data = b;
		t.last = last;
		ingress_q.push_back(t);
	endtask

	// Queue n bytes of a packet with the given header fields; pause at byte split if nonzero
	task automatic queue_packet(input int unsigned n, input logic [7:0] b0,
			input logic [15:0] tot, input logic [7:0] proto, input logic [7:0] doff_b,
			input int unsigned split);
		int unsigned hdr;
		logic [7:0]  b;
		hdr = 4 * int'((b0[3:0] < IHL_MIN) ? IHL_MIN : b0[3:0]);
		for (int unsigned i = 0; i < n; i++) begin
			if (split != 0 && i == split)
				wait_drain();
			b = 8'($urandom_range(255));
			if (i == POS_VER_IHL)
				b = b0;
			else if (i == POS_LEN_HI)
				b = tot[15:8];
			else if (i == POS_LEN_LO)
				b = tot[7:0];
			else if (i == POS_PROTO)
				b = proto;
			else if (proto == PROTO_TCP && i == hdr + POS_TCP_DOFF_REL)
				b = doff_b;
			push_byte(b, i == n - 1);
		end
	endtask

	// Mostly well-formed TCP/UDP packets, some other protocols and broken ones
	task automatic queue_random_packet(output int unsigned n_out);
		int unsigned ihl, doff, l4len, tot, n;
		logic [7:0]  b0, proto, doff_b;
		ihl = $urandom_range(1) ? 5 : $urandom_range(6, 15);
		doff = $urandom_range(1) ? 5 : $urandom_range(6, 15);
		case ($urandom_range(9))
			0, 1, 2, 3: proto = PROTO_TCP;
			4, 5, 6, 7: proto = PROTO_UDP;
			default:    proto = 8'($urandom_range(255));
		endcase
		l4len = ((proto == PROTO_TCP) ? doff * 4 : 8) + $urandom_range(0, 16);
		tot = ihl * 4 + l4len;
		n = tot;
		b0 = {4'h4, ihl[3:0]};
		doff_b = {doff[3:0], 4'($urandom_range(15))};
		if ($urandom_range(99) >= 80) begin
			case ($urandom_range(4))
				0: n = $urandom_range(1, tot);
				1: n = tot + $urandom_range(1, 8);
				2: begin
					b0 = 8'($urandom_range(255));
					doff_b = 8'($urandom_range(255));
				end
				3: tot = $urandom_range(0, ihl * 4 + 8);
				default: tot = $urandom_range(0, 65535);
			endcase
		end
		queue_packet(n, b0, tot[15:0], proto, doff_b, 0);
		n_out = n;
	endtask

	task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
		int unsigned queued, n;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		queued = 0;
		while (queued < 210) begin
			queue_random_packet(n);
			queued += n;
		end
		wait_drain();
	endtask

	initial begin : stim_proc
		logic [7:0] b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_XOR_KEY, 8'hFF);
		write_reg(CFG_CSUM_ENABLE, 8'h01);

		// Packets that end on the first byte and before the protocol byte
		push_byte(8'h00, 1'b1);
		push_byte(8'h4F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		// UDP packet whose checksum comes out zero and goes out as all ones
		for (int unsigned i = 0; i < 30; i++) begin
			case (i)
				0:       b = 8'h45;
				3:       b = 8'd30;
				9:       b = PROTO_UDP;
				26, 27:  b = 8'($urandom_range(255));
				28:      b = 8'hFF ^ key_sh;
				29:      b = 8'hE4 ^ key_sh;
				default: b = 8'h00;
			endcase
			push_byte(b, i == 29);
		end
		// TCP with header length and data offset below minimum, cut inside the check field
		queue_packet(37, 8'h40, 16'd60, PROTO_TCP, 8'h0F, 0);
		wait_drain();

		// No idling, with the sender holding off mid-packet until all outputs are back
		write_reg(CFG_XOR_KEY, 8'($urandom_range(1, 254)));
		queue_packet(48, 8'h45, 16'd48, PROTO_TCP, 8'h50, 24);
		run_phase(0, 0);

		write_reg(CFG_XOR_KEY, 8'h00);
		write_reg(CFG_CSUM_ENABLE, 8'hFE);
		run_phase(80, 0);

		write_reg(CFG_XOR_KEY, 8'hFF);
		write_reg(CFG_CSUM_ENABLE, 8'h01);
		run_phase(0, 80);

		write_reg(CFG_XOR_KEY, 8'($urandom_range(255)));
		write_reg(CFG_CSUM_ENABLE, 8'($urandom_range(255)));
		write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
		write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
		run_phase(19, 19);

		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(12 * 400000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
